// File: hw/rtl/mss_pkg.sv
// Shared types and constants for the model-syntax statement splitter.
// No dependencies; used by every module of the block.
package mss_pkg;

  localparam int MAX_BRACE_DEPTH = 255;
  localparam int DEPTH_W         = $clog2(MAX_BRACE_DEPTH + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // input kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // character classes
  localparam logic [3:0] CLS_OTHER  = 4'd0;
  localparam logic [3:0] CLS_OP     = 4'd1;
  localparam logic [3:0] CLS_WS     = 4'd2;
  localparam logic [3:0] CLS_HASH   = 4'd3;
  localparam logic [3:0] CLS_NL     = 4'd4;
  localparam logic [3:0] CLS_SEMI   = 4'd5;
  localparam logic [3:0] CLS_LBRACE = 4'd6;
  localparam logic [3:0] CLS_RBRACE = 4'd7;
  localparam logic [3:0] CLS_END    = 4'd8;

  // result events
  localparam logic [1:0] EV_KEPT = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_DONE = 2'd2;
  localparam logic [1:0] EV_ERR  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_STRAY = 3'd1;
  localparam logic [2:0] ERR_SEMI  = 3'd2;
  localparam logic [2:0] ERR_UNBAL = 3'd3;
  localparam logic [2:0] ERR_DEEP  = 3'd4;

  // characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef struct packed {
    logic [3:0] cls;
    logic [7:0] chr;
  } item_t;

endpackage

// File: hw/rtl/mss_front.sv
// Front end: accepts input beats and classifies each byte.
// Depends on mss_pkg.
module mss_front (
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] text_byte
  input  logic             in_tuser,   // [0] kind
  input  logic             q_full,
  output logic             q_push,
  output mss_pkg::item_t   q_item
);

  logic [3:0] cls;

  always_comb begin
    cls = mss_pkg::CLS_OTHER;
    if (in_tuser == mss_pkg::KIND_END) begin
      cls = mss_pkg::CLS_END;
    end else begin
      unique case (in_tdata)
        mss_pkg::CH_LBRACE: cls = mss_pkg::CLS_LBRACE;
        mss_pkg::CH_RBRACE: cls = mss_pkg::CLS_RBRACE;
        mss_pkg::CH_HASH:   cls = mss_pkg::CLS_HASH;
        mss_pkg::CH_SEMI:   cls = mss_pkg::CLS_SEMI;
        mss_pkg::CH_NL:     cls = mss_pkg::CLS_NL;
        mss_pkg::CH_TAB,
        mss_pkg::CH_SPACE:  cls = mss_pkg::CLS_WS;
        mss_pkg::CH_PLUS,
        mss_pkg::CH_STAR,
        mss_pkg::CH_EQ,
        mss_pkg::CH_TILDE,
        mss_pkg::CH_COLON:  cls = mss_pkg::CLS_OP;
        default:            cls = mss_pkg::CLS_OTHER;
      endcase
    end
  end

  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && !q_full;
  assign q_item.cls = cls;
  assign q_item.chr = in_tdata;

endmodule

// File: hw/rtl/mss_fifo.sv
// Short queue of classified beats between front and back end.
// Depends on mss_pkg.
module mss_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mss_pkg::item_t      push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output mss_pkg::item_t      head
);

  mss_pkg::item_t                mem [mss_pkg::FIFO_DEPTH];
  logic [mss_pkg::FIFO_AW-1:0]   wptr_r, wptr_nxt;
  logic [mss_pkg::FIFO_AW-1:0]   rptr_r, rptr_nxt;
  logic [mss_pkg::FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                          do_pop;

  assign full   = (cnt_r == (mss_pkg::FIFO_AW+1)'(mss_pkg::FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign head   = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_item;
    end
  end

endmodule

// File: hw/rtl/mss_back.sv
// Back end: splitter state, output register; one classified beat per cycle unless the full output register is stalled.
// Depends on mss_pkg.
module mss_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  mss_pkg::item_t   q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic [mss_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic                        cmt_r, cmt_nxt;
  logic                        cont_r, cont_nxt;
  logic                        pend_r, pend_nxt;
  logic                        err_r, err_nxt;

  logic                        ov_r, ov_nxt;
  logic [1:0]                  ev_r, ev_nxt;
  logic [7:0]                  kb_r, kb_nxt;
  logic [2:0]                  ec_r, ec_nxt;
  logic                        done_r, done_nxt;

  logic                        go;
  logic                        emit;
  logic                        lb, rb;
  logic [mss_pkg::DEPTH_W-1:0] d_new;

  assign q_pop = !q_empty && (!ov_r || out_tready);
  assign go    = q_pop;

  always_comb begin
    depth_nxt = depth_r;
    cmt_nxt   = cmt_r;
    cont_nxt  = cont_r;
    pend_nxt  = pend_r;
    err_nxt   = err_r;
    emit      = 1'b0;
    ev_nxt    = ev_r;
    kb_nxt    = kb_r;
    ec_nxt    = ec_r;
    done_nxt  = done_r;
    lb        = (q_head.cls == mss_pkg::CLS_LBRACE) && !cmt_r;
    rb        = (q_head.cls == mss_pkg::CLS_RBRACE) && !cmt_r;
    d_new     = depth_r;

    if (go) begin
      ev_nxt   = mss_pkg::EV_DONE;
      kb_nxt   = '0;
      ec_nxt   = mss_pkg::ERR_NONE;
      done_nxt = 1'b0;
      if (q_head.cls == mss_pkg::CLS_END) begin
        depth_nxt = '0;
        cmt_nxt   = 1'b0;
        cont_nxt  = 1'b0;
        pend_nxt  = 1'b0;
        err_nxt   = 1'b0;
        emit      = 1'b1;
        done_nxt  = 1'b1;
        priority if (err_r) begin
          ev_nxt = mss_pkg::EV_DONE;
        end else if (depth_r != '0) begin
          ev_nxt = mss_pkg::EV_ERR;
          ec_nxt = mss_pkg::ERR_UNBAL;
        end else if (pend_r) begin
          ev_nxt = mss_pkg::EV_END;
        end else begin
          ev_nxt = mss_pkg::EV_DONE;
        end
      end else if (!err_r) begin
        priority if (lb && depth_r == mss_pkg::DEPTH_W'(mss_pkg::MAX_BRACE_DEPTH)) begin
          err_nxt = 1'b1;
          emit    = 1'b1;
          ev_nxt  = mss_pkg::EV_ERR;
          ec_nxt  = mss_pkg::ERR_DEEP;
        end else if (rb && depth_r == '0) begin
          err_nxt = 1'b1;
          emit    = 1'b1;
          ev_nxt  = mss_pkg::EV_ERR;
          ec_nxt  = mss_pkg::ERR_STRAY;
        end else begin
          if (lb) begin
            d_new = depth_r + 1'b1;
          end else if (rb) begin
            d_new = depth_r - 1'b1;
          end
          depth_nxt = d_new;
          if (d_new != '0) begin
            pend_nxt = 1'b1;
            emit     = 1'b1;
            ev_nxt   = mss_pkg::EV_KEPT;
            kb_nxt   = q_head.chr;
          end else begin
            unique case (q_head.cls)
              mss_pkg::CLS_WS: begin
              end
              mss_pkg::CLS_HASH: begin
                cmt_nxt = 1'b1;
              end
              mss_pkg::CLS_NL: begin
                cmt_nxt = 1'b0;
                if (!cont_r && pend_r) begin
                  pend_nxt = 1'b0;
                  emit     = 1'b1;
                  ev_nxt   = mss_pkg::EV_END;
                end
              end
              mss_pkg::CLS_SEMI: begin
                if (!cmt_r) begin
                  if (cont_r) begin
                    err_nxt = 1'b1;
                    emit    = 1'b1;
                    ev_nxt  = mss_pkg::EV_ERR;
                    ec_nxt  = mss_pkg::ERR_SEMI;
                  end else if (pend_r) begin
                    pend_nxt = 1'b0;
                    emit     = 1'b1;
                    ev_nxt   = mss_pkg::EV_END;
                  end
                end
              end
              default: begin
                if (!cmt_r) begin
                  cont_nxt = (q_head.cls == mss_pkg::CLS_OP);
                  pend_nxt = 1'b1;
                  emit     = 1'b1;
                  ev_nxt   = mss_pkg::EV_KEPT;
                  kb_nxt   = q_head.chr;
                end
              end
            endcase
          end
        end
      end
    end

    if (go) begin
      ov_nxt = emit;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      cmt_r   <= 1'b0;
      cont_r  <= 1'b0;
      pend_r  <= 1'b0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      cmt_r   <= cmt_nxt;
      cont_r  <= cont_nxt;
      pend_r  <= pend_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r   <= ev_nxt;
    kb_r   <= kb_nxt;
    ec_r   <= ec_nxt;
    done_r <= done_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {5'b0, ec_r, kb_r};
  assign out_tlast  = done_r;

endmodule

// File: hw/rtl/model_syntax_statement_splitter_core.sv
// Top level of the model-syntax statement splitter.
// Depends on mss_pkg, mss_front, mss_fifo and mss_back.
//
// Usage:
//   Input channel in_*: one text byte or end-of-text marker per beat.
//   in_tdata carries the byte, in_tuser the kind (1 = end of text).
//   Output channel out_*: zero or one result beat per input beat.
//   out_tuser is the event (kept byte, statement end, done, error),
//   out_tdata carries the kept byte and the error code, out_tlast marks
//   the result answering an end-of-text beat.
//   Throughput: one input beat per cycle sustained while out_tready is
//   high. An accepted beat is written into the queue, then processed
//   into the output register, which raises out_tvalid and holds the result.
//   The back end retires one queued beat per cycle whenever the output
//   register is empty or being drained.
//   Reset (rst_n low, synchronous) empties the queue and output register
//   and clears all splitter state.
//   When out_tready is low a full output register holds and the back end
//   stops; the queue absorbs up to four more beats before in_tready drops.
module model_syntax_statement_splitter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] kept_byte, [10:8] error_code, [15:11] zero
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast
);

  logic           q_full, q_push, q_pop, q_empty;
  mss_pkg::item_t q_in, q_head;

  mss_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  mss_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  mss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
